### rtl/core/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator.
// Used by bsa_front, bsa_back and bitmap_slot_allocator in rtl/core; depends on nothing.
package bsa_pkg;

  localparam int ADDR_W        = 32;
  localparam int SIZE_W        = 13;
  localparam int COUNT_W       = 9;
  localparam int IDX_W         = COUNT_W;
  localparam int OFF_W         = SIZE_W + IDX_W;
  localparam int PROD_W        = SIZE_W + IDX_W;
  localparam int ROW_W         = 32;
  localparam int ROW_SH        = 5;
  localparam int BITS_PER_STEP = 3;
  localparam int DIV_STEPS     = IDX_W / BITS_PER_STEP;
  localparam int STEP_W        = 2;
  localparam int REG_IDX_W     = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;
  localparam logic [1:0] ST_NOT_USED = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_SLOT_BASE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SLOT_SIZE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SLOT_COUNT = 2'd2;

  localparam logic [ADDR_W-1:0]  SLOT_BASE_RST  = 32'd0;
  localparam logic [SIZE_W-1:0]  SLOT_SIZE_RST  = 13'd128;
  localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 9'd256;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] slot_address;
  } res_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [SIZE_W-1:0]  size;
    logic [COUNT_W-1:0] count;
  } cfg_t;

  typedef struct packed {
    logic             operation;
    logic             bad;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_CHECK,
    FS_DIV,
    FS_FIN,
    FS_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_ISSUE,
    BS_ALOOK,
    BS_FLOOK,
    BS_MUL,
    BS_RESP
  } back_state_t;

endpackage

### rtl/core/bsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/bsa_fifo.sv
// Small synchronous queue used between the allocator stages and on the result side.
// Generic over the element type; no package dependency.
module bsa_fifo #(
  parameter type elem_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  elem_t wdata,
  output logic  full,
  input  logic  pop,
  output elem_t rdata,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  elem_t         mem [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] cnt;
  logic          do_push;
  logic          do_pop;

  assign full    = cnt == CW'(DEPTH);
  assign empty   = cnt == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

endmodule

### rtl/core/bsa_front.sv
// Front end: takes requests, checks free addresses and finds the slot index
// with a 3-bit-per-cycle restoring divider. Depends on bsa_pkg.
module bsa_front import bsa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic push,
  output logic full,
  input  req_t request,
  output logic cmd_push,
  output cmd_t cmd,
  input  logic cmd_full
);

  front_state_t             state;
  front_state_t             state_next;
  logic                     operation;
  logic [ADDR_W-1:0]        address;
  logic [ADDR_W-1:0]        off;
  logic                     early_bad;
  logic [OFF_W-1:0]         rem;
  logic [OFF_W-1:0]         rem_next;
  logic [OFF_W-1:0]         dvs;
  logic [IDX_W-1:0]         quo;
  logic [BITS_PER_STEP-1:0] qbits;
  logic [STEP_W-1:0]        step;

  assign off = address - cfg.base;

  // quotient must stay below 2^IDX_W, otherwise the slot is out of range anyway
  assign early_bad = (address < cfg.base) || (cfg.size == '0) ||
                     (off >= ADDR_W'({cfg.size, {IDX_W{1'b0}}}));

  always_comb begin
    rem_next = rem;
    qbits    = '0;
    for (int j = BITS_PER_STEP - 1; j >= 0; j--) begin
      if (rem_next >= (dvs << j)) begin
        rem_next = rem_next - (dvs << j);
        qbits[j] = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FS_IDLE: begin
        if (push) begin
          state_next = FS_CHECK;
        end
      end
      FS_CHECK: begin
        if (operation == OP_FREE && !early_bad) begin
          state_next = FS_DIV;
        end else begin
          state_next = FS_PUSH;
        end
      end
      FS_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = FS_FIN;
        end
      end
      FS_FIN: begin
        state_next = FS_PUSH;
      end
      FS_PUSH: begin
        if (!cmd_full) begin
          state_next = FS_IDLE;
        end
      end
      default: state_next = FS_IDLE;
    endcase
  end

  always_comb begin
    full     = 1'b1;
    cmd_push = 1'b0;
    unique case (state)
      FS_IDLE: full = 1'b0;
      FS_PUSH: cmd_push = !cmd_full;
      default: full = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
    if (state == FS_IDLE && push) begin
      operation <= request.operation;
      address   <= request.address;
    end
    if (state == FS_CHECK) begin
      rem           <= off[OFF_W-1:0];
      dvs           <= OFF_W'(cfg.size) << (IDX_W - BITS_PER_STEP);
      step          <= '0;
      cmd.operation <= operation;
      cmd.bad       <= (operation == OP_FREE) && early_bad;
      cmd.idx       <= '0;
    end
    if (state == FS_DIV) begin
      rem  <= rem_next;
      dvs  <= dvs >> BITS_PER_STEP;
      quo  <= {quo[IDX_W-BITS_PER_STEP-1:0], qbits};
      step <= step + 1'b1;
    end
    if (state == FS_FIN) begin
      cmd.bad <= (rem != '0) || (quo >= cfg.count);
      cmd.idx <= quo;
    end
  end

endmodule

### rtl/core/bsa_back.sv
// Back end: owns the in-use bitmap (32-bit rows in RAM, per-row valid and full
// flags), runs first-fit allocate and free. Depends on bsa_pkg and bsa_ram.
module bsa_back import bsa_pkg::*; #(
  parameter int MAX_SLOTS = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cfg_t                           cfg,
  input  logic                           cmd_empty,
  input  cmd_t                           cmd,
  output logic                           cmd_pop,
  input  logic                           res_full,
  output logic                           res_push,
  output res_t                           result,
  output logic [$clog2(MAX_SLOTS+1)-1:0] used_count
);

  localparam int ROWS   = (MAX_SLOTS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

  back_state_t       state;
  back_state_t       state_next;
  cmd_t              cur;
  logic [ROWS-1:0]   row_valid;
  logic [ROWS-1:0]   row_full;
  logic [ROW_AW-1:0] row;
  logic [ROW_AW-1:0] find_row;
  logic [ROW_AW-1:0] free_row;
  logic [ROW_AW-1:0] raddr;
  logic              found;
  logic [ROW_W-1:0]  rd_data;
  logic [ROW_W-1:0]  row_data;
  logic [ROW_W-1:0]  wdata;
  logic              we;
  logic [ROW_SH-1:0] bit_pos;
  logic              any_free;
  logic [ROW_SH-1:0] bit_sel;
  logic              hit;
  logic [IDX_W-1:0]  slot_idx;
  logic [PROD_W-1:0] prod;
  logic [1:0]        status;

  assign free_row = ROW_AW'(cur.idx >> ROW_SH);
  assign bit_sel  = cur.idx[ROW_SH-1:0];
  assign row_data = row_valid[row] ? rd_data : '0;
  assign hit      = row_data[bit_sel];

  always_comb begin
    found    = 1'b0;
    find_row = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if ((r * ROW_W < int'(cfg.count)) && !(row_valid[r] && row_full[r])) begin
        found    = 1'b1;
        find_row = ROW_AW'(r);
      end
    end
  end

  always_comb begin
    any_free = 1'b0;
    bit_pos  = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (!row_data[b] && (int'(row) * ROW_W + b < int'(cfg.count))) begin
        any_free = 1'b1;
        bit_pos  = ROW_SH'(b);
      end
    end
  end

  assign raddr = (cur.operation == OP_ALLOC) ? find_row : free_row;

  always_comb begin
    we    = 1'b0;
    wdata = row_data;
    if (state == BS_ALOOK) begin
      we    = any_free;
      wdata = row_data | (ROW_W'(1) << bit_pos);
    end else if (state == BS_FLOOK) begin
      we    = hit;
      wdata = row_data & ~(ROW_W'(1) << bit_sel);
    end
  end

  bsa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (row),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      BS_IDLE: begin
        if (!cmd_empty && !res_full) begin
          state_next = BS_ISSUE;
        end
      end
      BS_ISSUE: begin
        if (cur.bad || (cur.operation == OP_ALLOC && !found)) begin
          state_next = BS_RESP;
        end else if (cur.operation == OP_ALLOC) begin
          state_next = BS_ALOOK;
        end else begin
          state_next = BS_FLOOK;
        end
      end
      BS_ALOOK: state_next = any_free ? BS_MUL : BS_RESP;
      BS_FLOOK: state_next = BS_RESP;
      BS_MUL:   state_next = BS_RESP;
      BS_RESP:  state_next = BS_IDLE;
      default:  state_next = BS_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop             = 1'b0;
    res_push            = 1'b0;
    result.status       = status;
    result.slot_address = '0;
    unique case (state)
      BS_IDLE: cmd_pop = !cmd_empty && !res_full;
      BS_RESP: begin
        res_push = 1'b1;
        if (status == ST_OK && cur.operation == OP_ALLOC) begin
          result.slot_address = cfg.base + ADDR_W'(prod);
        end
      end
      default: cmd_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BS_IDLE;
      row_valid  <= '0;
      row_full   <= '0;
      used_count <= '0;
    end else begin
      state <= state_next;
      if (we) begin
        row_valid[row] <= 1'b1;
        row_full[row]  <= &wdata;
      end
      if (state == BS_ALOOK && any_free) begin
        used_count <= used_count + CNT_W'(1);
      end else if (state == BS_FLOOK && hit && used_count != '0) begin
        used_count <= used_count - CNT_W'(1);
      end
    end
    if (state == BS_IDLE) begin
      cur <= cmd;
    end
    if (state == BS_ISSUE) begin
      row <= raddr;
      if (cur.bad) begin
        status <= ST_BAD_ADDR;
      end else if (cur.operation == OP_ALLOC && !found) begin
        status <= ST_FULL;
      end
    end
    if (state == BS_ALOOK) begin
      status   <= any_free ? ST_OK : ST_FULL;
      slot_idx <= IDX_W'({row, bit_pos});
    end
    if (state == BS_FLOOK) begin
      status <= hit ? ST_OK : ST_NOT_USED;
    end
    if (state == BS_MUL) begin
      prod <= PROD_W'(slot_idx) * PROD_W'(cfg.size);
    end
  end

endmodule

### rtl/core/bitmap_slot_allocator.sv
// Allocates are paced by the back end (row read, bit search, multiply), frees by the
// front-end divider (3 quotient bits a cycle); through the command queue the front end
// takes a new request while the back end still works on an earlier one.
// Reset (rst, synchronous, active high): queues empty, registers to their reset
// values, every slot free through per-row valid flags; no clearing pass.
module bitmap_slot_allocator import bsa_pkg::*; #(
  parameter int MAX_SLOTS = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  req_t                 request,
  output logic                 empty,
  input  logic                 pop,
  output res_t                 result,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  localparam int          CNT_W = $clog2(MAX_SLOTS + 1);
  localparam logic [12:0] MAX_W = 13'(MAX_SLOTS);

  logic [ADDR_W-1:0]  slot_base;
  logic [SIZE_W-1:0]  slot_size;
  logic [COUNT_W-1:0] slot_count;
  cfg_t               cfg;
  logic               cmd_push;
  cmd_t               cmd_in;
  logic               cmd_full;
  logic               cmd_pop;
  cmd_t               cmd_head;
  logic               cmd_empty;
  logic               res_push;
  res_t               res_in;
  logic               res_full;
  logic [CNT_W-1:0]   used_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_base  <= SLOT_BASE_RST;
      slot_size  <= SLOT_SIZE_RST;
      slot_count <= SLOT_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SLOT_BASE:  slot_base  <= cfg_data;
        REG_SLOT_SIZE:  slot_size  <= cfg_data[SIZE_W-1:0];
        REG_SLOT_COUNT: slot_count <= cfg_data[COUNT_W-1:0];
        default:        slot_base  <= slot_base;
      endcase
    end
  end

  assign cfg.base  = slot_base;
  assign cfg.size  = slot_size;
  assign cfg.count = ({4'd0, slot_count} > MAX_W) ? MAX_W[COUNT_W-1:0] : slot_count;

  bsa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .request  (request),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  bsa_fifo #(
    .elem_t (cmd_t),
    .DEPTH  (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );

  bsa_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd_empty  (cmd_empty),
    .cmd        (cmd_head),
    .cmd_pop    (cmd_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .result     (res_in),
    .used_count (used_count)
  );

  bsa_fifo #(
    .elem_t (res_t),
    .DEPTH  (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

`ifndef SYNTHESIS
  a_res_room: assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("result transfer into a full queue");

  a_cmd_room: assert property (@(posedge clk) disable iff (rst) cmd_push |-> !cmd_full)
    else $error("command transfer into a full queue");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CNT_W'(MAX_SLOTS))
    else $error("used slot count above capacity");

  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("not idle after reset");
`endif

endmodule

### sim/tb.sv
// Self-checking testbench for bitmap_slot_allocator: directed and random allocate/free
// traffic with random idling and back-pressure, checked against an in-bench predictor.
// Depends on rtl/core/bsa_pkg.sv and rtl/core/bitmap_slot_allocator.sv.
module tb import bsa_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 256;
  localparam int QUIET_LIMIT = 2000;

  class alloc_scoreboard;
    logic [ADDR_W-1:0]  base;
    logic [SIZE_W-1:0]  size;
    logic [COUNT_W-1:0] count;
    bit                 in_use[DEPTH];
    res_t               expected_q[$];
    int                 errors;

    function new();
      base   = SLOT_BASE_RST;
      size   = SLOT_SIZE_RST;
      count  = SLOT_COUNT_RST;
      errors = 0;
      foreach (in_use[i]) in_use[i] = 1'b0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
      case (idx)
        REG_SLOT_BASE:  base  = data;
        REG_SLOT_SIZE:  size  = data[SIZE_W-1:0];
        REG_SLOT_COUNT: count = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int slots();
      return (count > DEPTH) ? DEPTH : int'(count);
    endfunction

    function logic [ADDR_W-1:0] slot_addr(int i);
      return base + 32'(i) * 32'(size);
    endfunction

    function int pick_slot(bit used);
      int found[$];
      for (int i = 0; i < slots(); i++)
        if (in_use[i] == used) found.push_back(i);
      if (found.size() == 0) return -1;
      return found[$urandom_range(0, found.size() - 1)];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // accepted request -> expected transfer on the result side
    function void note_request(req_t r);
      res_t              e;
      logic [ADDR_W-1:0] off;
      logic [ADDR_W-1:0] q;
      bit                done;
      e.status       = ST_FULL;
      e.slot_address = '0;
      done           = 1'b0;
      if (r.operation == OP_ALLOC) begin
        for (int i = 0; i < slots(); i++) begin
          if (!done && !in_use[i]) begin
            in_use[i]      = 1'b1;
            e.status       = ST_OK;
            e.slot_address = slot_addr(i);
            done           = 1'b1;
          end
        end
      end else if (r.address < base || size == 0) begin
        e.status = ST_BAD_ADDR;
      end else begin
        off = r.address - base;
        q   = off / 32'(size);
        if (off % 32'(size) != 0 || q >= 32'(slots())) begin
          e.status = ST_BAD_ADDR;
        end else if (!in_use[q]) begin
          e.status = ST_NOT_USED;
        end else begin
          in_use[q] = 1'b0;
          e.status  = ST_OK;
        end
      end
      expected_q.push_back(e);
    endfunction

    function void check_result(res_t a);
      res_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d slot_address %h", a.status, a.slot_address);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (a.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, a.status);
        errors++;
      end
      if (a.slot_address !== e.slot_address) begin
        $error("slot_address: expected %h, actual %h", e.slot_address, a.slot_address);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  req_t                 request;
  logic                 empty;
  logic                 pop;
  res_t                 result;
  logic                 cfg_write;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  alloc_scoreboard sb = new();
  bit              no_idle;
  int              hold_request;
  int              quiet_cycles;

  bitmap_slot_allocator #(.MAX_SLOTS(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random pops, long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) sb.check_result(result);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || ($urandom_range(0, 99) >= 35);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input req_t r);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 35) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push    <= 1'b1;
    request <= r;
    do @(posedge clk); while (full);
    sb.note_request(r);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [ADDR_W-1:0] b, input logic [SIZE_W-1:0] s,
                            input logic [COUNT_W-1:0] c);
    logic [REG_IDX_W-1:0] idxs[3];
    logic [ADDR_W-1:0]    vals[3];
    idxs = '{REG_SLOT_BASE, REG_SLOT_SIZE, REG_SLOT_COUNT};
    vals = '{b, 32'(s), 32'(c)};
    drain();
    for (int k = 0; k < 3; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= idxs[k];
      cfg_data  <= vals[k];
      @(posedge clk);
      sb.write_reg(idxs[k], vals[k]);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic req_t random_request(int alloc_pct);
    req_t r;
    int   idx;
    int   kind;
    r.operation = OP_FREE;
    r.address   = $urandom();
    if ($urandom_range(0, 99) < alloc_pct) begin
      r.operation = OP_ALLOC;
      return r;
    end
    idx  = sb.pick_slot(1'b1);
    kind = $urandom_range(0, 9);
    if (kind < 7 && idx >= 0) begin
      r.address = sb.slot_addr(idx);
    end else begin
      case (kind % 5)
        1: r.address = sb.slot_addr($urandom_range(0, sb.slots()))
                       + $urandom_range(1, (sb.size > 1) ? sb.size - 1 : 1);
        2: r.address = sb.base - $urandom_range(1, 1000);
        3: r.address = sb.slot_addr(sb.slots() + $urandom_range(0, 3));
        4: begin
          idx = sb.pick_slot(1'b0);
          if (idx >= 0) r.address = sb.slot_addr(idx);
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic run_phase(input int alloc_pct, input int items);
    for (int i = 0; i < items; i++) send(random_request(alloc_pct));
  endtask

  initial begin
    logic [SIZE_W-1:0]  sz;
    logic [COUNT_W-1:0] cnt;
    rst          <= 1'b1;
    push         <= 1'b0;
    request      <= '0;
    cfg_write    <= 1'b0;
    cfg_index    <= REG_SLOT_BASE;
    cfg_data     <= '0;
    no_idle      = 1'b0;
    hold_request = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: first fit, double free, misaligned, past the end, top address
    send(req_t'{OP_ALLOC, 32'd0});
    send(req_t'{OP_ALLOC, 32'hFFFF_FFFF});
    send(req_t'{OP_FREE, 32'd128});
    send(req_t'{OP_FREE, 32'd128});
    send(req_t'{OP_FREE, 32'd64});
    send(req_t'{OP_FREE, 32'd32768});
    send(req_t'{OP_FREE, 32'hFFFF_FFFF});
    // top base, widest size, count above depth: address wraps
    set_config(32'hFFFF_FFFF, 13'd8191, 9'd511);
    send(req_t'{OP_ALLOC, 32'd0});
    send(req_t'{OP_FREE, 32'd0});
    send(req_t'{OP_FREE, 32'hFFFF_FFFF});
    // zero slot size
    set_config(32'h0000_0100, 13'd0, 9'd4);
    send(req_t'{OP_ALLOC, 32'd0});
    send(req_t'{OP_FREE, 32'h0000_0100});
    // zero slot count
    set_config(32'h55AA_0000, 13'd1, 9'd0);
    send(req_t'{OP_ALLOC, 32'd0});
    send(req_t'{OP_FREE, 32'h55AA_0000});
    // fill a small pool, then shrink it over a slot in use
    set_config(32'h0000_2000, 13'd4096, 9'd3);
    send(req_t'{OP_ALLOC, 32'd0});
    send(req_t'{OP_ALLOC, 32'd0});
    set_config(32'h0000_2000, 13'd4096, 9'd1);
    send(req_t'{OP_FREE, 32'h0000_4000});
    send(req_t'{OP_ALLOC, 32'd0});
    set_config(32'h0000_2000, 13'd4096, 9'd3);
    send(req_t'{OP_FREE, 32'h0000_4000});
    send(req_t'{OP_FREE, 32'h0000_2000});
    send(req_t'{OP_FREE, 32'h0000_3000});
    send(req_t'{OP_FREE, 32'h0000_1FFF});

    set_config($urandom(), 13'($urandom_range(1, 4096)), 9'd16);
    no_idle = 1'b1;
    run_phase(55, 150);
    no_idle = 1'b0;

    set_config(32'hFFFF_0000, 13'd4096, 9'd256);
    hold_request = 300;
    run_phase(70, 250);

    set_config($urandom(), 13'd1, 9'd1);
    run_phase(50, 60);

    for (int ph = 0; ph < 6; ph++) begin
      sz  = (ph == 0) ? 13'd0 : (ph == 3) ? 13'd4096 : 13'($urandom_range(1, 64));
      cnt = (ph == 1) ? 9'd300 : 9'($urandom_range(2, 40));
      set_config($urandom(), sz, cnt);
      run_phase((ph % 2 == 0) ? 60 : 45, 110);
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
